>>> sv/isort_pkg.sv
// Shared types and constants for the insertion sorter.
package isort_pkg;

  localparam int unsigned VAL_W = 32;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic insert;  // new value placed into the sorted row
    logic drain;   // row shifts toward cell 0 by one place
  } ctrl_t;

endpackage

>>> sv/insertion_sorter_core.sv
// Top level of the stable ascending insertion sorter.
//
//  channel  | ports                                    | transfer when
//  ---------+------------------------------------------+--------------------------
//  input    | start_i, busy_o, value_i                 | start_i high, busy_o low
//  result   | out_valid_o, sorted_value_o, last_o      | out_valid_o high
//
// Each accepted value is placed by a row of COUNT cells: every cell compares
// the broadcast value with its own and either holds, takes the new value, or
// takes its lower neighbor's value. The COUNT-th value of a set starts a drain
// in which the row shifts toward cell 0 and cell 0 is presented; busy_o is high
// for the whole drain. Reset clears the occupancy bits and the drain state;
// cell values are unset. Results cannot be held off by the receiver.
module insertion_sorter_core #(
  parameter int unsigned COUNT = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic signed [isort_pkg::VAL_W-1:0]  value_i,
  output logic                                out_valid_o,
  output logic signed [isort_pkg::VAL_W-1:0]  sorted_value_o,
  output logic                                last_o
);

  localparam int unsigned CNT_W = $clog2(COUNT);

  isort_pkg::ctrl_t                   ctrl;
  logic [COUNT-1:0]                   ins, occ;
  logic signed [isort_pkg::VAL_W-1:0] val [COUNT];

  logic             draining_q, draining_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             accept, drain_done;

  assign accept     = start_i && !draining_q;
  assign drain_done = draining_q && (cnt_q == CNT_W'(COUNT - 1));

  assign ctrl.insert = accept;
  assign ctrl.drain  = draining_q;

  // Row of cells; cell 0 holds the smallest value.
  for (genvar i = 0; i < COUNT; i++) begin : g_cell
    logic                               p_ins, p_occ, n_occ;
    logic signed [isort_pkg::VAL_W-1:0] p_val, n_val;

    if (i == 0) begin : g_first
      assign p_ins = 1'b0;
      assign p_occ = 1'b1;
      assign p_val = '0;
    end else begin : g_mid
      assign p_ins = ins[i-1];
      assign p_occ = occ[i-1];
      assign p_val = val[i-1];
    end

    if (i == COUNT - 1) begin : g_last
      assign n_occ = 1'b0;
      assign n_val = '0;
    end else begin : g_up
      assign n_occ = occ[i+1];
      assign n_val = val[i+1];
    end

    isort_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .value_i    (value_i),
      .prev_ins_i (p_ins),
      .prev_occ_i (p_occ),
      .prev_val_i (p_val),
      .next_occ_i (n_occ),
      .next_val_i (n_val),
      .ins_o      (ins[i]),
      .occ_o      (occ[i]),
      .val_o      (val[i])
    );
  end

  // Set completes when the value lands while all but the top cell are full.
  always_comb begin
    draining_d = draining_q;
    cnt_d      = cnt_q;
    if (draining_q) begin
      cnt_d = cnt_q + 1'b1;
      if (drain_done) begin
        draining_d = 1'b0;
        cnt_d      = '0;
      end
    end else if (accept && occ[COUNT-2]) begin
      draining_d = 1'b1;
      cnt_d      = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      draining_q <= 1'b0;
      cnt_q      <= '0;
    end else begin
      draining_q <= draining_d;
      cnt_q      <= cnt_d;
    end
  end

  assign busy_o         = draining_q;
  assign out_valid_o    = draining_q;
  assign sorted_value_o = val[0];
  assign last_o         = drain_done;

  // A drain starts only with a full row.
  a_full_at_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(draining_q) |-> (&occ))
    else $error("drain started with an empty cell");

  // Every presented result comes from an occupied cell.
  a_out_occupied: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> occ[0])
    else $error("result taken from an empty cell");

  // Outside a drain the top cell is never occupied.
  a_top_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !draining_q |-> !occ[COUNT-1])
    else $error("row full outside drain");

  // After the final result the row is empty and input is open again.
  a_empty_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_o |=> (!busy_o && (occ == '0)))
    else $error("row not cleared after final result");

endmodule

>>> sv/isort_cell.sv
// One compare-and-shift cell of the sorting chain.
module isort_cell (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  isort_pkg::ctrl_t                    ctrl_i,
  input  logic signed [isort_pkg::VAL_W-1:0]  value_i,
  // from the cell below (toward cell 0)
  input  logic                                prev_ins_i,
  input  logic                                prev_occ_i,
  input  logic signed [isort_pkg::VAL_W-1:0]  prev_val_i,
  // from the cell above
  input  logic                                next_occ_i,
  input  logic signed [isort_pkg::VAL_W-1:0]  next_val_i,
  output logic                                ins_o,
  output logic                                occ_o,
  output logic signed [isort_pkg::VAL_W-1:0]  val_o
);

  logic                               occ_q, occ_d;
  logic signed [isort_pkg::VAL_W-1:0] val_q, val_d;

  // Insertion point at or below this cell: strictly greater, or first free slot.
  assign ins_o = occ_q ? (value_i < val_q) : 1'b1;

  always_comb begin
    occ_d = occ_q;
    val_d = val_q;
    if (ctrl_i.drain) begin
      occ_d = next_occ_i;
      val_d = next_val_i;
    end else if (ctrl_i.insert) begin
      occ_d = occ_q | prev_occ_i;
      if (ins_o && prev_ins_i) begin
        val_d = prev_val_i;
      end else if (ins_o) begin
        val_d = value_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign occ_o = occ_q;
  assign val_o = val_q;

endmodule
